// ----- src/doctype_splice_offset_finder_defines.svh -----
// Assertion macros for the doctype splice offset finder.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef DOCTYPE_SPLICE_OFFSET_FINDER_DEFINES_SVH
`define DOCTYPE_SPLICE_OFFSET_FINDER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define DSOF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsof: same-cycle check failed");
// next-cycle implication
`define DSOF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsof: next-cycle check failed");
`else
`define DSOF_ASSERT_IMP(lbl, ante, cons)
`define DSOF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/dsof_pkg.sv -----
// Shared types, constants and helpers of the doctype splice offset finder.
// No dependencies; imported by every module of the block.
package dsof_pkg;

  localparam int unsigned OffsetW = 18;
  localparam int unsigned CountW  = 17;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned MarkIdxW = 4;
  localparam logic [MarkIdxW-1:0] MarkerLen = 4'd9;
  localparam logic [LimitW-1:0] ScanLimitRst = 16'd1024;

  localparam logic [7:0] Bom0 = 8'hEF;
  localparam logic [7:0] Bom1 = 8'hBB;
  localparam logic [7:0] Bom2 = 8'hBF;
  localparam logic [7:0] CloseBracket = 8'h3E;

  localparam logic [OffsetW-1:0] FloorBom = 18'd3;

  typedef enum logic [2:0] {
    PH_BOM  = 3'd0,
    PH_WS   = 3'd1,
    PH_MARK = 3'd2,
    PH_BRKT = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [OffsetW-1:0] splice_offset;
    logic               doctype_found;
  } out_word_t;

  typedef struct packed {
    phase_e              phase;
    logic [OffsetW-1:0]  byte_position;
    logic                has_bom;
    logic [CountW-1:0]   space_count;
    logic [MarkIdxW-1:0] marker_index;
    logic [CountW-1:0]   bracket_count;
  } state_t;

  localparam state_t StateRst = '{
    phase:         PH_BOM,
    byte_position: '0,
    has_bom:       1'b0,
    space_count:   '0,
    marker_index:  '0,
    bracket_count: '0
  };

  function automatic logic [7:0] marker_char(input logic [MarkIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = 8'h3C; // '<'
      4'd1: c = 8'h21; // '!'
      4'd2: c = 8'h64; // 'd'
      4'd3: c = 8'h6F; // 'o'
      4'd4: c = 8'h63; // 'c'
      4'd5: c = 8'h74; // 't'
      4'd6: c = 8'h79; // 'y'
      4'd7: c = 8'h70; // 'p'
      4'd8: c = 8'h65; // 'e'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bom_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = Bom0;
      2'd1: c = Bom1;
      default: c = Bom2;
    endcase
    return c;
  endfunction

  function automatic logic is_html_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
  endfunction

endpackage

// ----- src/doctype_splice_offset_finder.sv -----
// Doctype splice offset finder: takes one body byte per word and returns, once per body,
// the offset just after a leading "<!doctype ...>" (or the 0/3 floor set by a UTF-8 BOM).
// Throughput is one word per clock while no result is held by out_stall_i; a word passes
// an input register and then the result register, which raises out_valid_o for the
// deciding byte, and a result held by out_stall_i holds the input as well.
// scan_limit is written by cfg_we_i/cfg_data_i and must only change while the block is idle.
`include "doctype_splice_offset_finder_defines.svh"

module doctype_splice_offset_finder import dsof_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_data_i
);

  logic              word_valid;
  in_word_t          word;
  logic              advance;
  state_t            st_d, st_q;
  logic              emit;
  out_word_t         result;
  logic [LimitW-1:0] scan_limit_q;
  logic              out_valid_d, out_valid_q;
  out_word_t         out_data_d, out_data_q;

  assign advance = word_valid && (!out_valid_q || !out_stall_i);

  dsof_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  dsof_step u_step (
    .st_i         (st_q),
    .word_i       (word),
    .scan_limit_i (scan_limit_q),
    .st_o         (st_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StateRst;
      scan_limit_q <= ScanLimitRst;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        scan_limit_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `DSOF_ASSERT_IMP(a_found_past_marker, out_valid_o && out_data_o.doctype_found,
                   out_data_o.splice_offset >= 18'd10)
  `DSOF_ASSERT_IMP(a_floor_only, out_valid_o && !out_data_o.doctype_found,
                   out_data_o.splice_offset == 18'd0 || out_data_o.splice_offset == FloorBom)
  `DSOF_ASSERT_NXT(a_rearm_on_last, advance && word.is_last,
                   st_q.phase == PH_BOM && st_q.byte_position == '0)
  `DSOF_ASSERT_IMP(a_bom_position, st_q.has_bom, st_q.byte_position >= FloorBom)
  `DSOF_ASSERT_NXT(a_no_overwrite, out_valid_q && out_stall_i, out_valid_q && $stable(out_data_q))

endmodule

// ----- src/dsof_in_stage.sv -----
// Input register of the doctype splice offset finder.
// Holds one word until the step logic takes it; uses dsof_pkg.
module dsof_in_stage import dsof_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  input  logic     advance_i,
  output logic     word_valid_o,
  output in_word_t word_o
);

  logic     valid_d, valid_q;
  in_word_t word_d, word_q;

  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        word_d = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ----- src/dsof_step.sv -----
// Per-word step of the doctype splice offset finder: next scan state and result.
// Purely combinational; uses dsof_pkg.
module dsof_step import dsof_pkg::*; (
  input  state_t            st_i,
  input  in_word_t          word_i,
  input  logic [LimitW-1:0] scan_limit_i,
  output state_t            st_o,
  output logic              emit_o,
  output out_word_t         result_o
);

  always_comb begin
    state_t             st;
    logic               cont;
    logic               emit;
    logic [OffsetW-1:0] offset;
    logic               found;
    logic [OffsetW-1:0] base_off;
    logic [CountW-1:0]  limit;
    logic [7:0]         b;
    logic               last;

    st       = st_i;
    cont     = 1'b1;
    emit     = 1'b0;
    offset   = '0;
    found    = 1'b0;
    base_off = st_i.has_bom ? FloorBom : '0;
    limit    = {1'b0, scan_limit_i};
    b        = word_i.body_byte;
    last     = word_i.is_last;

    // byte order mark
    if (st.phase == PH_BOM) begin
      if (st.byte_position == '0 && b != Bom0) begin
        st.phase = PH_WS;
      end else if (st.byte_position > 18'd2 || b != bom_char(st.byte_position[1:0])) begin
        cont = 1'b0;
        emit = 1'b1;
      end else if (st.byte_position == 18'd2) begin
        cont             = 1'b0;
        st.has_bom       = 1'b1;
        st.byte_position = FloorBom;
        st.phase         = PH_WS;
        emit             = last;
        offset           = FloorBom;
      end else begin
        cont             = 1'b0;
        st.byte_position = st.byte_position + 18'd1;
        emit             = last;
      end
    end

    // whitespace skip
    if (cont && st.phase == PH_WS) begin
      if (st.space_count < limit && is_html_space(b)) begin
        cont             = 1'b0;
        st.space_count   = st.space_count + 17'd1;
        st.byte_position = st.byte_position + 18'd1;
        emit             = last;
        offset           = base_off;
      end else begin
        st.phase        = PH_MARK;
        st.marker_index = '0;
      end
    end

    if (cont) begin
      case (st.phase)
        PH_MARK: begin
          offset = base_off;
          if (st.marker_index >= MarkerLen || to_lower(b) != marker_char(st.marker_index)) begin
            emit = 1'b1;
          end else begin
            st.marker_index  = st.marker_index + 4'd1;
            st.byte_position = st.byte_position + 18'd1;
            if (st.marker_index == MarkerLen) begin
              st.phase         = PH_BRKT;
              st.bracket_count = {13'd0, MarkerLen};
              emit             = (st.bracket_count >= limit) || last;
            end else begin
              emit = last;
            end
          end
        end
        PH_BRKT: begin
          offset = base_off;
          if (st.bracket_count >= limit) begin
            emit = 1'b1;
          end else if (b == CloseBracket) begin
            emit   = 1'b1;
            offset = st.byte_position + 18'd1;
            found  = 1'b1;
          end else begin
            st.bracket_count = st.bracket_count + 17'd1;
            st.byte_position = st.byte_position + 18'd1;
            emit             = (st.bracket_count >= limit) || last;
          end
        end
        default: begin
          // absorbing: wait for the final byte
        end
      endcase
    end

    if (last) begin
      st = StateRst;
    end else if (emit) begin
      st.phase = PH_DONE;
    end

    st_o     = st;
    emit_o   = emit;
    result_o = '{splice_offset: offset, doctype_found: found};
  end

endmodule
